[rtl/dtq_pkg.sv]
`timescale 1ns / 1ps
package dtq_pkg;

   // Request codes.
   localparam logic [2:0] REQ_ARM_ABS   = 3'd0;
   localparam logic [2:0] REQ_ARM_AFTER = 3'd1;
   localparam logic [2:0] REQ_CANCEL    = 3'd2;
   localparam logic [2:0] REQ_EXPIRE    = 3'd3;
   localparam logic [2:0] REQ_STATS     = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_ARM_DONE = 3'd0;
   localparam logic [2:0] KIND_CANCEL   = 3'd1;
   localparam logic [2:0] KIND_FIRED    = 3'd2;
   localparam logic [2:0] KIND_EXP_DONE = 3'd3;
   localparam logic [2:0] KIND_STATS    = 3'd4;

   typedef enum logic [2:0] {
      IDX_HOLD     = 3'd0,
      IDX_ZERO     = 3'd1,
      IDX_INC      = 3'd2,
      IDX_DEC      = 3'd3,
      IDX_LOAD_CNT = 3'd4
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX    = 2'd0,
      RD_IDX_P1 = 2'd1,
      RD_IDX_M1 = 2'd2,
      RD_IDX_PK = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_SHIFT  = 2'd1,
      WR_INSERT = 2'd2
   } wr_op_type;

   typedef struct packed {
      logic       latch_req;
      idx_op_type idx_op;
      logic       pos_save;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
      logic       arm_set;
      logic       unlink_done;
      logic       scan_end;
      logic       hold_slot;
      logic       calc_late;
      logic       fire;
      logic       load_resp;
   } cmd_type;

   typedef struct packed {
      logic in_slot_ok;
      logic in_slot_armed;
      logic idx_ge_cnt;
      logic idx_p1_ge_cnt;
      logic idx_gt_pos;
      logic idx_eq_k;
      logic ord_match;
      logic dl_le_deadline;
      logic dl_le_now;
      logic out_free;
      logic is_cancel;
   } status_type;

endpackage

[rtl/dtq_dp.sv]
`timescale 1ns / 1ps
module dtq_dp import dtq_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  stat,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_slot_id,
   input  logic [63:0] req_time_value,
   input  logic [63:0] req_now_time,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_kind,
   output logic [3:0]  rsp_fired_slot,
   output logic        rsp_was_armed,
   output logic [4:0]  rsp_pending_count,
   output logic [63:0] rsp_fired_total,
   output logic [63:0] rsp_max_lateness,
   output logic        rsp_last
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   logic [IW-1:0] ord_mem [NUM_SLOTS];
   logic [63:0]   dl_mem  [NUM_SLOTS];

   logic [2:0]     type_ff;
   logic [3:0]     slot_ff;
   logic           was_ff;
   logic [63:0]    deadline_ff;
   logic [63:0]    now_ff;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  pos_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  k_ff;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in;
   logic [IW-1:0]  h_ff;
   logic [63:0]    late_ff;
   logic [63:0]    fire_ff, fire_in;
   logic [63:0]    worst_ff, worst_in;
   logic [IW-1:0]  ord_q_ff;
   logic [63:0]    dl_q_ff;

   logic           out_valid_ff;
   logic [2:0]     out_kind_ff;
   logic [3:0]     out_slot_ff;
   logic           out_was_ff;
   logic [4:0]     out_pend_ff;
   logic [63:0]    out_total_ff;
   logic [63:0]    out_late_ff;
   logic           out_last_ff;

   logic [IW-1:0]  slot_idx;
   logic [CW-1:0]  rd_pos;
   logic [IW-1:0]  rd_addr;
   logic [2:0]     resp_kind;
   logic [3:0]     resp_slot;

   assign slot_idx = IW'(slot_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX_P1: rd_pos = idx_ff + CW'(1);
         RD_IDX_M1: rd_pos = idx_ff - CW'(1);
         RD_IDX_PK: rd_pos = idx_ff + k_ff;
         default:   rd_pos = idx_ff;
      endcase
      rd_addr = rd_pos[IW-1:0];
   end

   // Status toward the controller.
   always_comb begin
      stat.in_slot_ok     = {28'd0, req_slot_id} < 32'(NUM_SLOTS);
      stat.in_slot_armed  = armed_ff[IW'(req_slot_id)];
      stat.idx_ge_cnt     = idx_ff >= cnt_ff;
      stat.idx_p1_ge_cnt  = ({1'b0, idx_ff} + (CW+1)'(1)) >= {1'b0, cnt_ff};
      stat.idx_gt_pos     = idx_ff > pos_ff;
      stat.idx_eq_k       = idx_ff == k_ff;
      stat.ord_match      = ord_q_ff == slot_idx;
      stat.dl_le_deadline = dl_q_ff <= deadline_ff;
      stat.dl_le_now      = dl_q_ff <= now_ff;
      stat.out_free       = !out_valid_ff || rsp_ready;
      stat.is_cancel      = type_ff == REQ_CANCEL;
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_ZERO:     idx_in = '0;
         IDX_INC:      idx_in = idx_ff + CW'(1);
         IDX_DEC:      idx_in = idx_ff - CW'(1);
         IDX_LOAD_CNT: idx_in = cnt_ff;
         default:      idx_in = idx_ff;
      endcase

      cnt_in = cnt_ff;
      if (cmd.unlink_done) begin
         cnt_in = cnt_ff - CW'(1);
      end else if (cmd.arm_set) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.scan_end) begin
         cnt_in = cnt_ff - idx_ff;
      end

      armed_in = armed_ff;
      if (cmd.unlink_done) begin
         armed_in[slot_idx] = 1'b0;
      end
      if (cmd.arm_set) begin
         armed_in[slot_idx] = 1'b1;
      end
      if (cmd.fire) begin
         armed_in[h_ff] = 1'b0;
      end

      fire_in  = fire_ff + 64'd1;
      worst_in = (late_ff > worst_ff) ? late_ff : worst_ff;
   end

   always_comb begin
      resp_slot = slot_ff;
      unique case (type_ff) inside
         REQ_ARM_ABS, REQ_ARM_AFTER: resp_kind = KIND_ARM_DONE;
         REQ_CANCEL:                 resp_kind = KIND_CANCEL;
         REQ_EXPIRE: begin
            resp_kind = KIND_EXP_DONE;
            resp_slot = 4'd0;
         end
         default: begin
            resp_kind = KIND_STATS;
            resp_slot = 4'd0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         cnt_ff       <= '0;
         armed_ff     <= '0;
         fire_ff      <= '0;
         worst_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         armed_ff <= armed_in;
         if (cmd.fire) begin
            fire_ff  <= fire_in;
            worst_ff <= worst_in;
         end
         if (cmd.fire || cmd.load_resp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and memories.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         type_ff     <= req_type;
         slot_ff     <= req_slot_id;
         was_ff      <= stat.in_slot_ok && stat.in_slot_armed;
         deadline_ff <= (req_type == REQ_ARM_ABS) ? req_time_value
                                                  : req_now_time + req_time_value;
         now_ff      <= req_now_time;
      end
      if (cmd.pos_save) begin
         pos_ff <= idx_ff;
      end
      if (cmd.scan_end) begin
         k_ff <= idx_ff;
      end
      if (cmd.hold_slot) begin
         h_ff <= ord_q_ff;
      end
      if (cmd.calc_late) begin
         late_ff <= now_ff - dl_q_ff;
      end

      unique case (cmd.wr_op)
         WR_SHIFT:  ord_mem[idx_ff[IW-1:0]] <= ord_q_ff;
         WR_INSERT: ord_mem[pos_ff[IW-1:0]] <= slot_idx;
         default:   ;
      endcase
      ord_q_ff <= ord_mem[rd_addr];

      if (cmd.arm_set) begin
         dl_mem[slot_idx] <= deadline_ff;
      end
      dl_q_ff <= dl_mem[ord_q_ff];

      if (cmd.fire) begin
         out_kind_ff  <= KIND_FIRED;
         out_slot_ff  <= 4'(h_ff);
         out_was_ff   <= 1'b0;
         out_pend_ff  <= 5'(cnt_ff);
         out_total_ff <= fire_in;
         out_late_ff  <= worst_in;
         out_last_ff  <= 1'b0;
      end else if (cmd.load_resp) begin
         out_kind_ff  <= resp_kind;
         out_slot_ff  <= resp_slot;
         out_was_ff   <= (type_ff == REQ_CANCEL) && was_ff;
         out_pend_ff  <= 5'(cnt_ff);
         out_total_ff <= fire_ff;
         out_late_ff  <= worst_ff;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_fired_slot    = out_slot_ff;
   assign rsp_was_armed     = out_was_ff;
   assign rsp_pending_count = out_pend_ff;
   assign rsp_fired_total   = out_total_ff;
   assign rsp_max_lateness  = out_late_ff;
   assign rsp_last          = out_last_ff;

endmodule

[rtl/dtq_ctrl.sv]
`timescale 1ns / 1ps
module dtq_ctrl import dtq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_type,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [20:0] {
      ST_IDLE      = 21'd1,
      ST_UNL_RD    = 21'd2,
      ST_UNL_CMP   = 21'd4,
      ST_SHL_RD    = 21'd8,
      ST_SHL_WR    = 21'd16,
      ST_FIND_RD   = 21'd32,
      ST_FIND_DL   = 21'd64,
      ST_FIND_CMP  = 21'd128,
      ST_SHR_RD    = 21'd256,
      ST_SHR_WR    = 21'd512,
      ST_INS       = 21'd1024,
      ST_EXP_RD    = 21'd2048,
      ST_EXP_DL    = 21'd4096,
      ST_EXP_CMP   = 21'd8192,
      ST_FIRE_RD   = 21'd16384,
      ST_FIRE_DL   = 21'd32768,
      ST_FIRE_LATE = 21'd65536,
      ST_FIRE_EMIT = 21'd131072,
      ST_COMP_RD   = 21'd262144,
      ST_COMP_WR   = 21'd524288,
      ST_RESP      = 21'd1048576
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.idx_op      = IDX_HOLD;
      cmd.rd_sel      = RD_IDX;
      cmd.wr_op       = WR_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               cmd.idx_op    = IDX_ZERO;
               unique case (req_type) inside
                  REQ_ARM_ABS, REQ_ARM_AFTER: begin
                     if (stat.in_slot_ok && stat.in_slot_armed) begin
                        state_in = ST_UNL_RD;
                     end else if (stat.in_slot_ok) begin
                        state_in = ST_FIND_RD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  REQ_CANCEL: begin
                     state_in = (stat.in_slot_ok && stat.in_slot_armed) ? ST_UNL_RD
                                                                        : ST_RESP;
                  end
                  REQ_EXPIRE: state_in = ST_EXP_RD;
                  REQ_STATS:  state_in = ST_RESP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end

         // Search the order list for the slot being unlinked.
         ST_UNL_RD: state_in = ST_UNL_CMP;
         ST_UNL_CMP: begin
            if (stat.ord_match) begin
               state_in = ST_SHL_RD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_UNL_RD;
            end
         end

         // Close the gap left by the unlinked slot.
         ST_SHL_RD: begin
            if (stat.idx_p1_ge_cnt) begin
               cmd.unlink_done = 1'b1;
               cmd.idx_op      = IDX_ZERO;
               state_in        = stat.is_cancel ? ST_RESP : ST_FIND_RD;
            end else begin
               cmd.rd_sel = RD_IDX_P1;
               state_in   = ST_SHL_WR;
            end
         end
         ST_SHL_WR: begin
            cmd.wr_op  = WR_SHIFT;
            cmd.idx_op = IDX_INC;
            state_in   = ST_SHL_RD;
         end

         // Walk past every entry whose deadline is at or before the new one.
         ST_FIND_RD: begin
            if (stat.idx_ge_cnt) begin
               cmd.pos_save = 1'b1;
               cmd.idx_op   = IDX_LOAD_CNT;
               state_in     = ST_SHR_RD;
            end else begin
               state_in = ST_FIND_DL;
            end
         end
         ST_FIND_DL: state_in = ST_FIND_CMP;
         ST_FIND_CMP: begin
            if (stat.dl_le_deadline) begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_FIND_RD;
            end else begin
               cmd.pos_save = 1'b1;
               cmd.idx_op   = IDX_LOAD_CNT;
               state_in     = ST_SHR_RD;
            end
         end

         // Open a hole at the insert position, working from the tail.
         ST_SHR_RD: begin
            if (stat.idx_gt_pos) begin
               cmd.rd_sel = RD_IDX_M1;
               state_in   = ST_SHR_WR;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_SHR_WR: begin
            cmd.wr_op  = WR_SHIFT;
            cmd.idx_op = IDX_DEC;
            state_in   = ST_SHR_RD;
         end
         ST_INS: begin
            cmd.wr_op   = WR_INSERT;
            cmd.arm_set = 1'b1;
            state_in    = ST_RESP;
         end

         // Count the expired prefix first so every result carries the final count.
         ST_EXP_RD: begin
            if (stat.idx_ge_cnt) begin
               cmd.scan_end = 1'b1;
               cmd.idx_op   = IDX_ZERO;
               state_in     = ST_FIRE_RD;
            end else begin
               state_in = ST_EXP_DL;
            end
         end
         ST_EXP_DL: state_in = ST_EXP_CMP;
         ST_EXP_CMP: begin
            if (stat.dl_le_now) begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_EXP_RD;
            end else begin
               cmd.scan_end = 1'b1;
               cmd.idx_op   = IDX_ZERO;
               state_in     = ST_FIRE_RD;
            end
         end

         ST_FIRE_RD: begin
            if (stat.idx_eq_k) begin
               cmd.idx_op = IDX_ZERO;
               state_in   = ST_COMP_RD;
            end else begin
               state_in = ST_FIRE_DL;
            end
         end
         ST_FIRE_DL: begin
            cmd.hold_slot = 1'b1;
            state_in      = ST_FIRE_LATE;
         end
         ST_FIRE_LATE: begin
            cmd.calc_late = 1'b1;
            state_in      = ST_FIRE_EMIT;
         end
         ST_FIRE_EMIT: begin
            if (stat.out_free) begin
               cmd.fire   = 1'b1;
               cmd.idx_op = IDX_INC;
               state_in   = ST_FIRE_RD;
            end
         end

         // Move the surviving entries to the head of the list.
         ST_COMP_RD: begin
            if (stat.idx_ge_cnt) begin
               state_in = ST_RESP;
            end else begin
               cmd.rd_sel = RD_IDX_PK;
               state_in   = ST_COMP_WR;
            end
         end
         ST_COMP_WR: begin
            cmd.wr_op  = WR_SHIFT;
            cmd.idx_op = IDX_INC;
            state_in   = ST_COMP_RD;
         end

         ST_RESP: begin
            if (stat.out_free) begin
               cmd.load_resp = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/deadline_timer_queue.sv]
`timescale 1ns / 1ps
// Timer queue of NUM_SLOTS slots kept in deadline order in two memories (order
// list and per-slot deadline), each read once and written at most once per
// cycle, handled by a controller that walks the list one entry at a time.
// A stats request, or a cancel of an idle slot, goes straight to its result.
// Arming an idle slot runs only the insert walk; re-arming an armed slot first
// runs the unlink search and gap closing, and cancelling an armed slot runs
// those two alone. Expire scans the list for due entries, fires a result per
// due entry, then compacts the surviving entries to the head of the list.
// A result that finds the output register full waits on rsp_ready, stalling
// the controller. A new request is taken once the previous one has placed
// its last result in the output register, so results may wait on rsp_ready
// without blocking it.
module deadline_timer_queue import dtq_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_slot_id,
   input  logic [63:0] req_time_value,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [3:0]  rsp_fired_slot,
   output logic        rsp_was_armed,
   output logic [4:0]  rsp_pending_count,
   output logic [63:0] rsp_fired_total,
   output logic [63:0] rsp_max_lateness,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type stat;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dtq_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_slot_id       (req_slot_id),
      .req_time_value    (req_time_value),
      .req_now_time      (req_now_time),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_slot    (rsp_fired_slot),
      .rsp_was_armed     (rsp_was_armed),
      .rsp_pending_count (rsp_pending_count),
      .rsp_fired_total   (rsp_fired_total),
      .rsp_max_lateness  (rsp_max_lateness),
      .rsp_last          (rsp_last)
   );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench import dtq_pkg::*;;

   typedef struct {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic        was;
      logic [4:0]  pending;
      logic [63:0] total;
      logic [63:0] lateness;
      logic        last;
   } timer_result_type;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [63:0] tval;
      logic [63:0] now;
   } timer_req_type;

   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [3:0]  req_slot_id = '0;
   logic [63:0] req_time_value = '0;
   logic [63:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [3:0]  rsp_fired_slot;
   logic        rsp_was_armed;
   logic [4:0]  rsp_pending_count;
   logic [63:0] rsp_fired_total;
   logic [63:0] rsp_max_lateness;
   logic        rsp_last;

   deadline_timer_queue u_dut (.*);

   always #4 clock = ~clock;

   // Shadow timer state.
   logic [63:0] shadow_deadline [16];
   logic        shadow_armed [16];
   int unsigned deadline_order [$];
   logic [63:0] shadow_fires = '0;
   logic [63:0] shadow_worst = '0;

   timer_req_type    pending_reqs [$];
   timer_result_type expected_results [$];
   timer_req_type    accepted_req;
   int               errors = 0;
   int unsigned      cycle_count = 0;
   int unsigned      quiet_cycles = 0;

   function automatic bit unlink_timer(int unsigned s);
      if (!shadow_armed[s]) return 1'b0;
      foreach (deadline_order[i]) begin
         if (deadline_order[i] == s) begin
            deadline_order.delete(i);
            break;
         end
      end
      shadow_armed[s] = 1'b0;
      return 1'b1;
   endfunction

   function automatic timer_result_type make_result(logic [2:0] kind, logic [3:0] slot,
                                                    logic was, logic last);
      timer_result_type r;
      r.kind = kind; r.slot = slot; r.was = was; r.pending = '0;
      r.total = shadow_fires; r.lateness = shadow_worst; r.last = last;
      return r;
   endfunction

   task automatic predict_timer_step(timer_req_type rq);
      timer_result_type step_out [$];
      logic [63:0]      dl;
      int unsigned      pos;
      int unsigned      head;
      bit               was;
      logic [63:0]      late;
      case (rq.op) inside
         REQ_ARM_ABS, REQ_ARM_AFTER: begin
            dl = (rq.op == REQ_ARM_ABS) ? rq.tval : rq.now + rq.tval;
            void'(unlink_timer(int'(rq.slot)));
            pos = 0;
            while (pos < deadline_order.size() &&
                   shadow_deadline[deadline_order[pos]] <= dl)
               pos++;
            deadline_order.insert(pos, int'(rq.slot));
            shadow_deadline[rq.slot] = dl;
            shadow_armed[rq.slot] = 1'b1;
            step_out.push_back(make_result(KIND_ARM_DONE, rq.slot, 1'b0, 1'b1));
         end
         REQ_CANCEL: begin
            was = unlink_timer(int'(rq.slot));
            step_out.push_back(make_result(KIND_CANCEL, rq.slot, was, 1'b1));
         end
         REQ_EXPIRE: begin
            while (deadline_order.size() > 0 &&
                   shadow_deadline[deadline_order[0]] <= rq.now) begin
               head = deadline_order.pop_front();
               shadow_armed[head] = 1'b0;
               shadow_fires++;
               late = rq.now - shadow_deadline[head];
               if (late > shadow_worst) shadow_worst = late;
               step_out.push_back(make_result(KIND_FIRED, 4'(head), 1'b0, 1'b0));
            end
            step_out.push_back(make_result(KIND_EXP_DONE, '0, 1'b0, 1'b1));
         end
         REQ_STATS: step_out.push_back(make_result(KIND_STATS, '0, 1'b0, 1'b1));
         default: ;
      endcase
      // Pending count reflects the state after the whole request.
      foreach (step_out[i]) begin
         step_out[i].pending = 5'(deadline_order.size());
         expected_results.push_back(step_out[i]);
      end
   endtask

   task automatic add_req(logic [2:0] op, logic [3:0] slot, logic [63:0] tval,
                          logic [63:0] now);
      timer_req_type rq;
      rq.op = op; rq.slot = slot; rq.tval = tval; rq.now = now;
      pending_reqs.push_back(rq);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idling is suppressed for a stretch at the start of every period of cycle_count.
   function automatic bit take_break();
      if ((cycle_count % 3000) < 600) return 1'b0;
      return $urandom_range(99, 0) < 18;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_req.op   = req_type;
            accepted_req.slot = req_slot_id;
            accepted_req.tval = req_time_value;
            accepted_req.now  = req_now_time;
            predict_timer_step(accepted_req);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && !take_break()) begin
               timer_req_type rq;
               rq = pending_reqs.pop_front();
               req_valid      <= 1'b1;
               req_type       <= rq.op;
               req_slot_id    <= rq.slot;
               req_time_value <= rq.tval;
               req_now_time   <= rq.now;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result kind %0d slot %0d", $time,
                        rsp_result_kind, rsp_fired_slot);
               errors++;
            end else begin
               timer_result_type e;
               e = expected_results.pop_front();
               if (e.kind !== rsp_result_kind || e.slot !== rsp_fired_slot ||
                   e.was !== rsp_was_armed || e.pending !== rsp_pending_count ||
                   e.total !== rsp_fired_total || e.lateness !== rsp_max_lateness ||
                   e.last !== rsp_last) begin
                  $display(
                     "%0t: expected kind %0d slot %0d armed %0d pend %0d tot %0d late %0d last %0d",
                     $time, e.kind, e.slot, e.was, e.pending, e.total, e.lateness, e.last);
                  $display(
                     "%0t: actual   kind %0d slot %0d armed %0d pend %0d tot %0d late %0d last %0d",
                     $time, rsp_result_kind, rsp_fired_slot, rsp_was_armed,
                     rsp_pending_count, rsp_fired_total, rsp_max_lateness, rsp_last);
                  errors++;
               end
            end
         end
         rsp_ready <= !take_break();
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] t_now;
      int          sel;
      int          n_real;
      foreach (shadow_armed[i]) begin
         shadow_armed[i] = 1'b0;
         shadow_deadline[i] = '0;
      end
      // Directed: extremes, equal deadlines, re-arm, wrap, cancel and ignored codes.
      add_req(REQ_STATS, 4'd0, '0, '0);
      add_req(REQ_EXPIRE, 4'd0, '0, '0);
      add_req(REQ_CANCEL, 4'd15, '0, '0);
      add_req(REQ_ARM_ABS, 4'd0, '0, '0);
      add_req(REQ_ARM_ABS, 4'd15, '1, '1);
      add_req(REQ_ARM_ABS, 4'd3, 64'd100, '0);
      add_req(REQ_ARM_ABS, 4'd4, 64'd100, '0);
      add_req(REQ_ARM_ABS, 4'd5, 64'd50, '0);
      add_req(REQ_ARM_ABS, 4'd3, 64'd100, '0);
      add_req(REQ_ARM_AFTER, 4'd7, 64'd10, '1);
      add_req(REQ_ARM_AFTER, 4'd8, 64'd40, 64'd20);
      add_req(REQ_CANCEL, 4'd8, '0, '0);
      add_req(REQ_CANCEL, 4'd8, '0, '0);
      add_req(3'd5, 4'd1, '1, '1);
      add_req(3'd6, 4'd2, '0, '0);
      add_req(3'd7, 4'd9, '1, '0);
      add_req(REQ_EXPIRE, 4'd0, '0, 64'd100);
      add_req(REQ_STATS, 4'd0, '0, '0);
      for (int s = 0; s < 16; s++) add_req(REQ_ARM_ABS, s[3:0], 64'd500 + (s % 3), '0);
      add_req(REQ_EXPIRE, 4'd0, '0, '1);
      add_req(REQ_STATS, 4'd0, '0, '0);

      t_now = 64'd1000;
      n_real = 0;
      while (n_real < 93) begin
         sel = $urandom_range(99, 0);
         if (sel < 40) begin
            add_req(REQ_ARM_ABS, 4'($urandom_range(15, 0)),
                    t_now + 64'($urandom_range(2000, 0)), rand64());
         end else if (sel < 55) begin
            add_req(REQ_ARM_AFTER, 4'($urandom_range(15, 0)),
                    64'($urandom_range(2000, 0)), t_now);
         end else if (sel < 65) begin
            add_req(REQ_CANCEL, 4'($urandom_range(15, 0)), rand64(), rand64());
         end else if (sel < 82) begin
            t_now = t_now + 64'($urandom_range(1500, 0));
            add_req(REQ_EXPIRE, 4'($urandom_range(15, 0)), rand64(), t_now);
         end else if (sel < 88) begin
            add_req(REQ_STATS, 4'($urandom_range(15, 0)), rand64(), rand64());
         end else if (sel < 96) begin
            add_req($urandom_range(1, 0) ? REQ_ARM_ABS : REQ_ARM_AFTER,
                    4'($urandom_range(15, 0)), rand64(), rand64());
         end else begin
            add_req(3'($urandom_range(7, 5)), 4'($urandom_range(15, 0)), rand64(),
                    rand64());
            n_real--;
         end
         n_real++;
      end
      add_req(REQ_EXPIRE, 4'd0, '0, '1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
